[rtl/core/pva_pkg.sv]
// Package for the polyphonic voice allocator: event and action codes, the
// controller state type and the command/status structs. No dependencies.
package pva_pkg;

  localparam int ModeBits   = 2;
  localparam int NoteBits   = 7;
  localparam int FvBits     = 3;
  localparam int VoiceBits  = 3;
  localparam int ActionBits = 3;

  localparam logic [ModeBits-1:0] MODE_ON   = 2'd0;
  localparam logic [ModeBits-1:0] MODE_OFF  = 2'd1;
  localparam logic [ModeBits-1:0] MODE_DONE = 2'd2;

  localparam logic [ActionBits-1:0] ACT_NONE    = 3'd0;
  localparam logic [ActionBits-1:0] ACT_RETRIG  = 3'd1;
  localparam logic [ActionBits-1:0] ACT_FRESH   = 3'd2;
  localparam logic [ActionBits-1:0] ACT_STEAL   = 3'd3;
  localparam logic [ActionBits-1:0] ACT_RELEASE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic commit;
  } pva_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic issue_last;
    logic out_free;
  } pva_status_t;

endpackage

[rtl/core/pva_if.sv]
// Handshake interfaces for the voice allocator's event and result channels.
// Depends on pva_pkg for the field widths.
interface pva_in_if import pva_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ModeBits-1:0] mode;
  logic [NoteBits-1:0] note;
  logic [FvBits-1:0]   finished_voice;

  modport source (output valid, mode, note, finished_voice, input ready);
  modport sink   (input valid, mode, note, finished_voice, output ready);
endinterface

interface pva_out_if import pva_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [VoiceBits-1:0]  voice;
  logic [ActionBits-1:0] action;

  modport source (output valid, voice, action, input ready);
  modport sink   (input valid, voice, action, output ready);
endinterface

[rtl/core/polyphonic_voice_allocator_top.sv]
// Top level of the polyphonic voice allocator: joins controller and datapath
// to the event and result channels. Depends on pva_pkg, pva_if, pva_ctrl, pva_dp.

// The allocator assigns VOICES synthesizer voice slots to notes. Each event
// beat (note on, note off, voice finished) yields exactly one result beat
// naming the slot acted upon and what was done to it. A note on retriggers a
// slot already holding the note, else takes the first silent slot, else steals
// the first releasing slot, else steals the slot with the oldest start stamp.
// Note on and note off walk all slots through the single read port of the
// slot note/stamp memory, one slot per cycle; a voice finished or unused
// event skips the slot scan and goes to commit. One event is worked on at a time.
// The result sits in an output register, so the next event beat is taken
// while an earlier result still waits for the sink. The stamp counter
// saturates; after that, ties in stamp go to the lowest slot index.
module polyphonic_voice_allocator_top import pva_pkg::*; #(
  parameter int VOICES     = 8,
  parameter int STAMP_BITS = 32
) (
  input logic clk,
  input logic rst_n,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch
);

  pva_cmd_t    cmd;
  pva_status_t status;

  // Sequencing: latch the event, scan slots, then commit the decision.
  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Slot state, scan trackers and the result register.
  pva_dp #(
    .VOICES     (VOICES),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_mode           (in_ch.mode),
    .in_note           (in_ch.note),
    .in_finished_voice (in_ch.finished_voice),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_voice         (out_ch.voice),
    .out_action        (out_ch.action)
  );

endmodule

[rtl/core/pva_ctrl.sv]
// Controller state machine of the voice allocator: sequences latch, slot scan
// and commit. Depends on pva_pkg.
module pva_ctrl import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pva_status_t status,
  output pva_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (!status.need_scan) begin
          state_nxt = ST_COMMIT;
        end else if (status.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = rst_n;
        cmd.start = in_valid && rst_n;
      end
      ST_SCAN: begin
        cmd.issue = status.need_scan;
      end
      ST_DRAIN: begin
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/pva_dp.sv]
// Datapath of the voice allocator: slot flags, slot note/stamp memory, scan
// trackers, stamp counter and result register. Depends on pva_pkg.
module pva_dp import pva_pkg::*; #(
  parameter int VOICES     = 8,
  parameter int STAMP_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pva_cmd_t              cmd,
  output pva_status_t           status,
  input  logic [ModeBits-1:0]   in_mode,
  input  logic [NoteBits-1:0]   in_note,
  input  logic [FvBits-1:0]     in_finished_voice,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VoiceBits-1:0]  out_voice,
  output logic [ActionBits-1:0] out_action
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MW = NoteBits + STAMP_BITS;
  localparam logic [STAMP_BITS-1:0] StampMax = {STAMP_BITS{1'b1}};

  // Slot note and stamp share one word; a retrigger rewrites the same note.
  logic [MW-1:0] mem [VOICES];
  logic [MW-1:0] q_r;
  logic [NoteBits-1:0]   q_note;
  logic [STAMP_BITS-1:0] q_stamp;

  logic [VOICES-1:0] alloc_r, alloc_nxt;
  logic [VOICES-1:0] sound_r, sound_nxt;
  logic [VOICES-1:0] rel_r, rel_nxt;
  logic [STAMP_BITS-1:0] ctr_r, ctr_nxt;

  logic [ModeBits-1:0] mode_r;
  logic [NoteBits-1:0] note_r;
  logic [FvBits-1:0]   fv_r;

  logic [IW-1:0] rd_idx_r;
  logic [IW-1:0] ev_idx_r;
  logic          ev_vld_r;

  // Candidate trackers; the match tracker also serves as first release hit.
  logic          have_mt_r, have_mt_nxt;
  logic [IW-1:0] mt_idx_r, mt_idx_nxt;
  logic          have_fr_r, have_fr_nxt;
  logic [IW-1:0] fr_idx_r, fr_idx_nxt;
  logic          have_rl_r, have_rl_nxt;
  logic [IW-1:0] rl_idx_r, rl_idx_nxt;
  logic          have_mn_r, have_mn_nxt;
  logic [IW-1:0] mn_idx_r, mn_idx_nxt;
  logic [STAMP_BITS-1:0] mn_stamp_r, mn_stamp_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VoiceBits-1:0]  voice_r, voice_nxt;
  logic [ActionBits-1:0] action_r, action_nxt;

  logic          wr_en;
  logic [IW-1:0] pick_idx;
  logic [IW-1:0] fv_idx;
  logic          fv_ok;
  logic [STAMP_BITS-1:0] new_stamp;

  assign q_note  = q_r[MW-1:STAMP_BITS];
  assign q_stamp = q_r[STAMP_BITS-1:0];
  assign fv_idx  = IW'(fv_r);
  assign fv_ok   = (32'(fv_r) < VOICES);
  assign new_stamp = (ctr_r == StampMax) ? ctr_r : ctr_r + 1'b1;

  assign status.need_scan  = (mode_r == MODE_ON) || (mode_r == MODE_OFF);
  assign status.issue_last = (rd_idx_r == IW'(VOICES - 1));
  assign status.out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (have_mt_r) begin
      pick_idx = mt_idx_r;
    end else if (have_fr_r) begin
      pick_idx = fr_idx_r;
    end else if (have_rl_r) begin
      pick_idx = rl_idx_r;
    end else begin
      pick_idx = mn_idx_r;
    end
  end

  assign wr_en = cmd.commit && (mode_r == MODE_ON);

  always_ff @(posedge clk) begin
    if (wr_en) mem[pick_idx] <= {note_r, new_stamp};
    q_r <= mem[rd_idx_r];
  end

  always_comb begin
    alloc_nxt     = alloc_r;
    sound_nxt     = sound_r;
    rel_nxt       = rel_r;
    ctr_nxt       = ctr_r;
    have_mt_nxt   = have_mt_r;
    mt_idx_nxt    = mt_idx_r;
    have_fr_nxt   = have_fr_r;
    fr_idx_nxt    = fr_idx_r;
    have_rl_nxt   = have_rl_r;
    rl_idx_nxt    = rl_idx_r;
    have_mn_nxt   = have_mn_r;
    mn_idx_nxt    = mn_idx_r;
    mn_stamp_nxt  = mn_stamp_r;
    voice_nxt     = voice_r;
    action_nxt    = action_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.start) begin
      have_mt_nxt = 1'b0;
      have_fr_nxt = 1'b0;
      have_rl_nxt = 1'b0;
      have_mn_nxt = 1'b0;
    end

    if (ev_vld_r) begin
      if (mode_r == MODE_ON) begin
        if (!have_mt_r && alloc_r[ev_idx_r] && (q_note == note_r)) begin
          have_mt_nxt = 1'b1;
          mt_idx_nxt  = ev_idx_r;
        end
        if (!have_fr_r && !sound_r[ev_idx_r]) begin
          have_fr_nxt = 1'b1;
          fr_idx_nxt  = ev_idx_r;
        end
        if (!have_rl_r && rel_r[ev_idx_r]) begin
          have_rl_nxt = 1'b1;
          rl_idx_nxt  = ev_idx_r;
        end
        // Strict compare keeps the lowest index on a tie.
        if (!have_mn_r || (q_stamp < mn_stamp_r)) begin
          have_mn_nxt  = 1'b1;
          mn_idx_nxt   = ev_idx_r;
          mn_stamp_nxt = q_stamp;
        end
      end else begin
        if (alloc_r[ev_idx_r] && sound_r[ev_idx_r] && !rel_r[ev_idx_r] &&
            (q_note == note_r)) begin
          rel_nxt[ev_idx_r] = 1'b1;
          if (!have_mt_r) begin
            have_mt_nxt = 1'b1;
            mt_idx_nxt  = ev_idx_r;
          end
        end
      end
    end

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      voice_nxt     = '0;
      action_nxt    = ACT_NONE;
      unique case (mode_r)
        MODE_ON: begin
          alloc_nxt[pick_idx] = 1'b1;
          sound_nxt[pick_idx] = 1'b1;
          rel_nxt[pick_idx]   = 1'b0;
          ctr_nxt             = new_stamp;
          voice_nxt           = VoiceBits'(pick_idx);
          if (have_mt_r) begin
            action_nxt = ACT_RETRIG;
          end else if (have_fr_r) begin
            action_nxt = ACT_FRESH;
          end else begin
            action_nxt = ACT_STEAL;
          end
        end
        MODE_OFF: begin
          if (have_mt_r) begin
            voice_nxt  = VoiceBits'(mt_idx_r);
            action_nxt = ACT_RELEASE;
          end
        end
        MODE_DONE: begin
          if (fv_ok) begin
            alloc_nxt[fv_idx] = 1'b0;
            sound_nxt[fv_idx] = 1'b0;
            rel_nxt[fv_idx]   = 1'b0;
            voice_nxt         = fv_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r     <= '0;
      sound_r     <= '0;
      rel_r       <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
      ev_vld_r    <= 1'b0;
      rd_idx_r    <= '0;
      have_mt_r   <= 1'b0;
      have_fr_r   <= 1'b0;
      have_rl_r   <= 1'b0;
      have_mn_r   <= 1'b0;
    end else begin
      alloc_r     <= alloc_nxt;
      sound_r     <= sound_nxt;
      rel_r       <= rel_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
      ev_vld_r    <= cmd.issue;
      have_mt_r   <= have_mt_nxt;
      have_fr_r   <= have_fr_nxt;
      have_rl_r   <= have_rl_nxt;
      have_mn_r   <= have_mn_nxt;
      if (cmd.start) begin
        rd_idx_r <= '0;
      end else if (cmd.issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_mode;
      note_r <= in_note;
      fv_r   <= in_finished_voice;
    end
    ev_idx_r   <= rd_idx_r;
    mt_idx_r   <= mt_idx_nxt;
    fr_idx_r   <= fr_idx_nxt;
    rl_idx_r   <= rl_idx_nxt;
    mn_idx_r   <= mn_idx_nxt;
    mn_stamp_r <= mn_stamp_nxt;
    voice_r    <= voice_nxt;
    action_r   <= action_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_voice  = voice_r;
  assign out_action = action_r;

endmodule

[rtl/core/pva_checker.sv]
// Port-level checker for the voice allocator, bound to the top level.
// Depends on pva_pkg and polyphonic_voice_allocator_top.
module pva_checker import pva_pkg::*; #(
  parameter int VOICES = 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VoiceBits-1:0]  out_voice,
  input logic [ActionBits-1:0] out_action
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_voice) && $stable(out_action))
    else $error("result beat changed while stalled");

  // One event at a time: the block is busy right after taking a beat.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("event beat taken while previous event in progress");

  // A result never appears at the edge right after an event is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !($past(in_valid) && $past(in_ready)))
    else $error("result appeared too early");

  // Reported slot lies inside the voice range.
  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (VOICES >= 8) || (32'(out_voice) < VOICES))
    else $error("result names a slot outside the voice range");

endmodule

bind polyphonic_voice_allocator_top pva_checker #(.VOICES(VOICES)) u_pva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_voice  (out_ch.voice),
  .out_action (out_ch.action)
);
